/* rtl/core/tbft_pkg.sv */
// Shared types, constants and arithmetic helpers of the tangent/binormal block.
// Depends on nothing; the multiplier, normalizer and top level use it.
`default_nettype none

package tbft_pkg;

  typedef logic signed [63:0] fix_t;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S8  = 2'd1,
    FMT_U16 = 2'd2,
    FMT_S16 = 2'd3
  } fmt_t;

  typedef enum logic [2:0] {
    REG_POS_FMT  = 3'd0,
    REG_POS_FRAC = 3'd1,
    REG_TEX_FMT  = 3'd2,
    REG_TEX_FRAC = 3'd3,
    REG_NRM_FMT  = 3'd4
  } reg_idx_t;

  localparam int MUL_LAT  = 5;
  localparam int NORM_LAT = 59;

  localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_MIN = -SUM_MAX;

  function automatic fix_t sat_add(fix_t a, fix_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > SUM_MAX) begin
      return SUM_MAX[63:0];
    end else if (s < SUM_MIN) begin
      return SUM_MIN[63:0];
    end
    return s[63:0];
  endfunction

  function automatic fix_t sat_sub(fix_t a, fix_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s > SUM_MAX) begin
      return SUM_MAX[63:0];
    end else if (s < SUM_MIN) begin
      return SUM_MIN[63:0];
    end
    return s[63:0];
  endfunction

  function automatic logic [3:0] normal_fraction(fmt_t fmt);
    logic [3:0] f;
    unique case (fmt)
      FMT_S8:  f = 4'd6;
      FMT_S16: f = 4'd14;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

  function automatic fix_t dequant(logic [15:0] raw, fmt_t fmt, logic [3:0] frac);
    logic signed [16:0] v;
    logic [16:0] m;
    logic [4:0] sh;
    logic [32:0] w;
    fix_t r;
    unique case (fmt)
      FMT_U8:  v = {9'd0, raw[7:0]};
      FMT_S8:  v = {{9{raw[7]}}, raw[7:0]};
      FMT_U16: v = {1'b0, raw};
      FMT_S16: v = {raw[15], raw};
    endcase
    m = v[16] ? 17'(-v) : 17'(v);
    sh = 5'd16 - {1'b0, frac};
    w = {16'd0, m} << sh;
    r = {31'd0, w};
    return v[16] ? -r : r;
  endfunction

  function automatic logic [15:0] quantize(fix_t v, fmt_t fmt);
    logic [62:0] m;
    logic [20:0] c;
    logic signed [21:0] q;
    logic [15:0] lane;
    m = v[63] ? 63'(-v) : v[62:0];
    unique case (fmt)
      FMT_S8:  m = m >> 10;
      FMT_S16: m = m >> 2;
      default: m = m >> 16;
    endcase
    c = (m > 63'd1048576) ? 21'd1048576 : m[20:0];
    q = v[63] ? -$signed({1'b0, c}) : $signed({1'b0, c});
    unique case (fmt)
      FMT_U8: begin
        if (q < 22'sd0) lane = 16'd0;
        else if (q > 22'sd255) lane = 16'h00FF;
        else lane = {8'd0, q[7:0]};
      end
      FMT_S8: begin
        if (q < -22'sd128) lane = 16'h0080;
        else if (q > 22'sd127) lane = 16'h007F;
        else lane = {8'd0, q[7:0]};
      end
      FMT_U16: begin
        if (q < 22'sd0) lane = 16'd0;
        else if (q > 22'sd65535) lane = 16'hFFFF;
        else lane = q[15:0];
      end
      FMT_S16: begin
        if (q < -22'sd32768) lane = 16'h8000;
        else if (q > 22'sd32767) lane = 16'h7FFF;
        else lane = q[15:0];
      end
    endcase
    return lane;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tbft_mulfix.sv */
// Pipelined saturating fixed-point multiplier, product shifted right by 16.
// Five register stages built from 32x32 partial products; uses tbft_pkg.
`default_nettype none

module tbft_mulfix (
  input  logic           clk,
  input  logic           en,
  input  tbft_pkg::fix_t a,
  input  tbft_pkg::fix_t b,
  output tbft_pkg::fix_t p
);

  logic [62:0] ua_r, ub_r;
  logic        neg_a_r, neg_b_r, neg_c_r, neg_d_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic [64:0] cross_r;
  logic [63:0] lo_r, hi_r;
  logic [62:0] mag_r;
  tbft_pkg::fix_t p_r;

  logic [127:0]   full;
  logic [62:0]    mag_nxt;
  tbft_pkg::fix_t p_nxt;

  always_comb begin
    full = {hi_r, lo_r} + {31'd0, cross_r, 32'd0};
    mag_nxt = (|full[127:79]) ? '1 : full[78:16];
    p_nxt = {1'b0, mag_r};
    if (neg_d_r) begin
      p_nxt = -p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r    <= a[63] ? 63'(-a) : a[62:0];
      ub_r    <= b[63] ? 63'(-b) : b[62:0];
      neg_a_r <= a[63] ^ b[63];
      p00_r   <= ua_r[31:0] * ub_r[31:0];
      p01_r   <= ua_r[31:0] * ub_r[62:32];
      p10_r   <= ua_r[62:32] * ub_r[31:0];
      p11_r   <= ua_r[62:32] * ub_r[62:32];
      neg_b_r <= neg_a_r;
      cross_r <= {1'b0, p01_r} + {1'b0, p10_r};
      lo_r    <= p00_r;
      hi_r    <= p11_r;
      neg_c_r <= neg_b_r;
      mag_r   <= mag_nxt;
      neg_d_r <= neg_c_r;
      p_r     <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

/* rtl/core/tbft_norm.sv */
// Pipelined vector normalizer: power-of-two prescale, sum of squares,
// bit-per-stage square root and restoring division. Uses tbft_pkg.
`default_nettype none

module tbft_norm (
  input  logic           clk,
  input  logic           en,
  input  tbft_pkg::fix_t t_in  [3],
  output tbft_pkg::fix_t t_out [3]
);

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 17;

  logic [62:0] m1_r [3];
  logic [62:0] m2_r [3];
  logic [62:0] m3_r [3];
  logic [62:0] m4_r [3];
  logic [62:0] m5_r [3];
  logic [2:0]  neg1_r, neg2_r, neg3_r, neg4_r, neg5_r, neg6_r, neg7_r, neg8_r, neg9_r;
  logic [62:0] mx2_r, mx3_r;
  logic [3:0]  nz4_r;
  logic [3:0]  pos4_r [4];
  logic        right5_r, zero5_r, zero6_r, zero7_r, zero8_r, zero9_r;
  logic [5:0]  amt5_r;
  logic [29:0] sm6_r [3];
  logic [29:0] sm7_r [3];
  logic [29:0] sm8_r [3];
  logic [29:0] sm9_r [3];
  logic [59:0] sq7_r [3];
  logic [60:0] sa8_r;
  logic [59:0] sq8_r;
  logic [61:0] s9_r;

  logic [62:0] x_r   [SQ_STEPS];
  logic [62:0] res_r [SQ_STEPS];
  logic [29:0] sqm_r [SQ_STEPS][3];
  logic        sqz_r [SQ_STEPS];
  logic [2:0]  sqn_r [SQ_STEPS];

  logic [46:0] rem_r [DIV_STEPS][3];
  logic [16:0] q_r   [DIV_STEPS][3];
  logic [30:0] dr_r  [DIV_STEPS];
  logic        dz_r  [DIV_STEPS];
  logic [2:0]  dn_r  [DIV_STEPS];

  tbft_pkg::fix_t t_out_r [3];

  logic [3:0]  nz4_nxt;
  logic [3:0]  pos4_nxt [4];
  logic [15:0] grp;
  logic [5:0]  msb;

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp = 16'(mx3_r >> (16 * g));
      nz4_nxt[g] = |grp;
      pos4_nxt[g] = 4'd0;
      for (int k = 0; k < 16; k++) begin
        if (grp[k]) begin
          pos4_nxt[g] = 4'(k);
        end
      end
    end
    msb = 6'd0;
    for (int g = 0; g < 4; g++) begin
      if (nz4_r[g]) begin
        msb = {2'(g), pos4_r[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i]   <= t_in[i][63] ? 63'(-t_in[i]) : t_in[i][62:0];
        neg1_r[i] <= t_in[i][63];
      end
      mx2_r  <= (m1_r[1] > m1_r[0]) ? m1_r[1] : m1_r[0];
      m2_r   <= m1_r;
      neg2_r <= neg1_r;
      mx3_r  <= (m2_r[2] > mx2_r) ? m2_r[2] : mx2_r;
      m3_r   <= m2_r;
      neg3_r <= neg2_r;
      nz4_r  <= nz4_nxt;
      pos4_r <= pos4_nxt;
      m4_r   <= m3_r;
      neg4_r <= neg3_r;
      right5_r <= msb > 6'd29;
      amt5_r   <= (msb > 6'd29) ? msb - 6'd29 : 6'd29 - msb;
      zero5_r  <= ~|nz4_r;
      m5_r     <= m4_r;
      neg5_r   <= neg4_r;
      for (int i = 0; i < 3; i++) begin
        sm6_r[i] <= right5_r ? 30'(m5_r[i] >> amt5_r) : 30'(m5_r[i] << amt5_r);
        sq7_r[i] <= sm6_r[i] * sm6_r[i];
      end
      zero6_r <= zero5_r;
      neg6_r  <= neg5_r;
      sm7_r   <= sm6_r;
      zero7_r <= zero6_r;
      neg7_r  <= neg6_r;
      sa8_r   <= {1'b0, sq7_r[0]} + {1'b0, sq7_r[1]};
      sq8_r   <= sq7_r[2];
      sm8_r   <= sm7_r;
      zero8_r <= zero7_r;
      neg8_r  <= neg7_r;
      s9_r    <= {1'b0, sa8_r} + {2'b0, sq8_r};
      sm9_r   <= sm8_r;
      zero9_r <= zero8_r;
      neg9_r  <= neg8_r;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam logic [62:0] STEP_BIT = 63'd1 << (62 - 2 * k);
    logic [62:0] x_in, res_in, sum, x_nxt, res_nxt;
    logic [29:0] m_in [3];
    logic        z_in;
    logic [2:0]  n_in;
    if (k == 0) begin : g_first
      assign x_in   = {1'b0, s9_r};
      assign res_in = '0;
      assign m_in   = sm9_r;
      assign z_in   = zero9_r;
      assign n_in   = neg9_r;
    end else begin : g_next
      assign x_in   = x_r[k-1];
      assign res_in = res_r[k-1];
      assign m_in   = sqm_r[k-1];
      assign z_in   = sqz_r[k-1];
      assign n_in   = sqn_r[k-1];
    end
    always_comb begin
      sum = res_in + STEP_BIT;
      if (x_in >= sum) begin
        x_nxt   = x_in - sum;
        res_nxt = (res_in >> 1) + STEP_BIT;
      end else begin
        x_nxt   = x_in;
        res_nxt = res_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= x_nxt;
        res_r[k] <= res_nxt;
        sqm_r[k] <= m_in;
        sqz_r[k] <= z_in;
        sqn_r[k] <= n_in;
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - 1 - j;
    logic [46:0] rem_in  [3];
    logic [16:0] q_in    [3];
    logic [46:0] rem_nxt [3];
    logic [16:0] q_nxt   [3];
    logic [30:0] r_in;
    logic        z_in;
    logic [2:0]  n_in;
    logic [47:0] cand;
    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = {1'b0, sqm_r[SQ_STEPS-1][i], 16'd0};
          q_in[i]   = '0;
        end
      end
      assign r_in = res_r[SQ_STEPS-1][30:0];
      assign z_in = sqz_r[SQ_STEPS-1];
      assign n_in = sqn_r[SQ_STEPS-1];
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign r_in   = dr_r[j-1];
      assign z_in   = dz_r[j-1];
      assign n_in   = dn_r[j-1];
    end
    always_comb begin
      cand = {17'd0, r_in} << K;
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, rem_in[i]} >= cand) begin
          rem_nxt[i] = 47'({1'b0, rem_in[i]} - cand);
          q_nxt[i]   = q_in[i] | (17'd1 << K);
        end else begin
          rem_nxt[i] = rem_in[i];
          q_nxt[i]   = q_in[i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
        dr_r[j]  <= r_in;
        dz_r[j]  <= z_in;
        dn_r[j]  <= n_in;
      end
    end
  end

  tbft_pkg::fix_t t_nxt [3];
  tbft_pkg::fix_t qv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv = {47'd0, q_r[DIV_STEPS-1][i]};
      if (dz_r[DIV_STEPS-1]) begin
        t_nxt[i] = '0;
      end else if (dn_r[DIV_STEPS-1][i]) begin
        t_nxt[i] = -qv;
      end else begin
        t_nxt[i] = qv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_out_r <= t_nxt;
    end
  end

  assign t_out = t_out_r;

endmodule

`default_nettype wire

/* rtl/core/tangent_binormal_from_triangle.sv */
// Per-corner tangent and binormal: dequantize, edge products, Gram-Schmidt,
// normalize, cross product and quantize. Uses tbft_pkg, tbft_mulfix, tbft_norm.
//
// The block is one fully pipelined datapath: it takes one word per cycle while
// in_ready is high and delivers each result through 87 pipeline stages and
// the output register. The depth comes mostly from the normalizer, whose
// square root resolves one bit per stage and whose divider resolves one
// quotient bit per stage, and from four chained five-stage multipliers. A
// two-entry output buffer lets the pipeline keep moving while a result waits;
// in_ready drops only when both entries are full. Configuration registers are
// written through the cfg port, which is always ready.
`default_nettype none

module tangent_binormal_from_triangle (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_position_a,
  input  logic [47:0] in_position_b,
  input  logic [47:0] in_position_c,
  input  logic [31:0] in_texcoord_a,
  input  logic [31:0] in_texcoord_b,
  input  logic [31:0] in_texcoord_c,
  input  logic [47:0] in_normal_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_tangent_out,
  output logic [47:0] out_binormal_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int ML        = tbft_pkg::MUL_LAT;
  localparam int N_DEPTH   = 3 * ML + tbft_pkg::NORM_LAT + 4;
  localparam int TAP_B     = ML;
  localparam int TAP_C     = 2 * ML + 2;
  localparam int T_DEPTH   = 2 * ML + 2;
  localparam int DET_DEPTH = N_DEPTH - 1;
  localparam int PIPE_LAT  = 4 * ML + tbft_pkg::NORM_LAT + 8;

  tbft_pkg::fmt_t pos_fmt_r, tex_fmt_r, nrm_fmt_r;
  logic [3:0]     pos_frac_r, tex_frac_r;

  logic en;
  logic [PIPE_LAT-1:0] v_r;

  logic [47:0] pos_w [3];
  logic [31:0] tex_w [3];

  tbft_pkg::fix_t p_r  [3][3];
  tbft_pkg::fix_t uv_r [3][2];
  tbft_pkg::fix_t nd_r [3];
  tbft_pkg::fix_t e1_r [3];
  tbft_pkg::fix_t e2_r [3];
  tbft_pkg::fix_t ne_r [3];
  tbft_pkg::fix_t du1_r, dv1_r, du2_r, dv2_r;
  tbft_pkg::fix_t tpa [3];
  tbft_pkg::fix_t tpb [3];
  tbft_pkg::fix_t dp0, dp1, det_full;
  tbft_pkg::fix_t t_r [3];
  logic           det_neg_r;
  tbft_pkg::fix_t n_dly_r [N_DEPTH][3];
  tbft_pkg::fix_t nt [3];
  tbft_pkg::fix_t pj1_r, nt2_r, proj_r;
  tbft_pkg::fix_t np [3];
  tbft_pkg::fix_t t_dly_r [T_DEPTH][3];
  tbft_pkg::fix_t t2_r [3];
  tbft_pkg::fix_t tn [3];
  tbft_pkg::fix_t bp [3];
  tbft_pkg::fix_t bm [3];
  tbft_pkg::fix_t tn_dly_r [ML][3];
  logic [DET_DEPTH-1:0] det_dly_r;
  tbft_pkg::fix_t b_r  [3];
  tbft_pkg::fix_t tf_r [3];
  logic [47:0] tan_q_r, bin_q_r;

  logic        out_valid_r, skid_full_r;
  logic [47:0] out_tan_r, out_bin_r, skid_tan_r, skid_bin_r;

  assign en        = ~skid_full_r;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  assign pos_w[0] = in_position_a;
  assign pos_w[1] = in_position_b;
  assign pos_w[2] = in_position_c;
  assign tex_w[0] = in_texcoord_a;
  assign tex_w[1] = in_texcoord_b;
  assign tex_w[2] = in_texcoord_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_fmt_r  <= tbft_pkg::FMT_S16;
      pos_frac_r <= 4'd0;
      tex_fmt_r  <= tbft_pkg::FMT_S16;
      tex_frac_r <= 4'd0;
      nrm_fmt_r  <= tbft_pkg::FMT_S16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tbft_pkg::REG_POS_FMT:  pos_fmt_r  <= tbft_pkg::fmt_t'(cfg_data[1:0]);
        tbft_pkg::REG_POS_FRAC: pos_frac_r <= cfg_data;
        tbft_pkg::REG_TEX_FMT:  tex_fmt_r  <= tbft_pkg::fmt_t'(cfg_data[1:0]);
        tbft_pkg::REG_TEX_FRAC: tex_frac_r <= cfg_data;
        tbft_pkg::REG_NRM_FMT:  nrm_fmt_r  <= tbft_pkg::fmt_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          p_r[k][i] <= tbft_pkg::dequant(pos_w[k][16*i +: 16], pos_fmt_r, pos_frac_r);
        end
        for (int j = 0; j < 2; j++) begin
          uv_r[k][j] <= tbft_pkg::dequant(tex_w[k][16*j +: 16], tex_fmt_r, tex_frac_r);
        end
      end
      for (int i = 0; i < 3; i++) begin
        nd_r[i] <= tbft_pkg::dequant(in_normal_in[16*i +: 16], nrm_fmt_r,
                                     tbft_pkg::normal_fraction(nrm_fmt_r));
        e1_r[i] <= tbft_pkg::sat_sub(p_r[1][i], p_r[0][i]);
        e2_r[i] <= tbft_pkg::sat_sub(p_r[2][i], p_r[0][i]);
      end
      ne_r  <= nd_r;
      du1_r <= tbft_pkg::sat_sub(uv_r[1][0], uv_r[0][0]);
      dv1_r <= tbft_pkg::sat_sub(uv_r[1][1], uv_r[0][1]);
      du2_r <= tbft_pkg::sat_sub(uv_r[2][0], uv_r[0][0]);
      dv2_r <= tbft_pkg::sat_sub(uv_r[2][1], uv_r[0][1]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_tmul
    tbft_mulfix u_tpa (.clk(clk), .en(en), .a(e2_r[i]), .b(dv1_r), .p(tpa[i]));
    tbft_mulfix u_tpb (.clk(clk), .en(en), .a(e1_r[i]), .b(dv2_r), .p(tpb[i]));
    tbft_mulfix u_nt (.clk(clk), .en(en), .a(n_dly_r[TAP_B][i]), .b(t_r[i]), .p(nt[i]));
    tbft_mulfix u_np (.clk(clk), .en(en), .a(n_dly_r[TAP_C][i]), .b(proj_r), .p(np[i]));
  end

  tbft_mulfix u_det0 (.clk(clk), .en(en), .a(du1_r), .b(dv2_r), .p(dp0));
  tbft_mulfix u_det1 (.clk(clk), .en(en), .a(dv1_r), .b(du2_r), .p(dp1));

  assign det_full = tbft_pkg::sat_sub(dp0, dp1);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t_r[i]  <= tbft_pkg::sat_sub(tpa[i], tpb[i]);
        t2_r[i] <= tbft_pkg::sat_sub(t_dly_r[T_DEPTH-1][i], np[i]);
      end
      det_neg_r <= det_full[63];
      n_dly_r[0] <= ne_r;
      for (int k = 1; k < N_DEPTH; k++) begin
        n_dly_r[k] <= n_dly_r[k-1];
      end
      t_dly_r[0] <= t_r;
      for (int k = 1; k < T_DEPTH; k++) begin
        t_dly_r[k] <= t_dly_r[k-1];
      end
      pj1_r  <= tbft_pkg::sat_add(nt[0], nt[1]);
      nt2_r  <= nt[2];
      proj_r <= tbft_pkg::sat_add(pj1_r, nt2_r);
    end
  end

  tbft_norm u_norm (.clk(clk), .en(en), .t_in(t2_r), .t_out(tn));

  for (genvar i = 0; i < 3; i++) begin : g_bmul
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    tbft_mulfix u_bp (.clk(clk), .en(en), .a(n_dly_r[N_DEPTH-1][I1]), .b(tn[I2]),
                      .p(bp[i]));
    tbft_mulfix u_bm (.clk(clk), .en(en), .a(n_dly_r[N_DEPTH-1][I2]), .b(tn[I1]),
                      .p(bm[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tn_dly_r[0] <= tn;
      for (int k = 1; k < ML; k++) begin
        tn_dly_r[k] <= tn_dly_r[k-1];
      end
      det_dly_r <= {det_dly_r[DET_DEPTH-2:0], det_neg_r};
      for (int i = 0; i < 3; i++) begin
        b_r[i]  <= tbft_pkg::sat_sub(bp[i], bm[i]);
        tf_r[i] <= det_dly_r[DET_DEPTH-1] ? -tn_dly_r[ML-1][i] : tn_dly_r[ML-1][i];
      end
      tan_q_r <= {tbft_pkg::quantize(tf_r[2], nrm_fmt_r),
                  tbft_pkg::quantize(tf_r[1], nrm_fmt_r),
                  tbft_pkg::quantize(tf_r[0], nrm_fmt_r)};
      bin_q_r <= {tbft_pkg::quantize(b_r[2], nrm_fmt_r),
                  tbft_pkg::quantize(b_r[1], nrm_fmt_r),
                  tbft_pkg::quantize(b_r[0], nrm_fmt_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_ready) begin
        skid_full_r <= 1'b0;
      end
    end else if (v_r[PIPE_LAT-1]) begin
      if (out_valid_r && !out_ready) begin
        skid_full_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_ready) begin
        out_tan_r <= skid_tan_r;
        out_bin_r <= skid_bin_r;
      end
    end else if (v_r[PIPE_LAT-1]) begin
      if (out_valid_r && !out_ready) begin
        skid_tan_r <= tan_q_r;
        skid_bin_r <= bin_q_r;
      end else begin
        out_tan_r <= tan_q_r;
        out_bin_r <= bin_q_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tangent_out  = out_tan_r;
  assign out_binormal_out = out_bin_r;

endmodule

`default_nettype wire
